@@ sv/aligned_read_flag_classifier_defines.svh @@
// Assertion macros shared by the read classifier RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef ALIGNED_READ_FLAG_CLASSIFIER_DEFINES_SVH
`define ALIGNED_READ_FLAG_CLASSIFIER_DEFINES_SVH
// same-cycle implication
`define ARFC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("arfc assertion failed");
// next-cycle implication
`define ARFC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("arfc assertion failed");
`endif

@@ sv/arfc_pkg.sv @@
// Types and constants of the aligned read flag classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package arfc_pkg;
   localparam int NUM_COUNTERS = 32;
   localparam int MAPQ_BINS    = 256;
   localparam int QDEPTH       = 4;

   // request kinds
   localparam logic [2:0] REQ_ADD  = 3'd0;
   localparam logic [2:0] REQ_CNT  = 3'd1;
   localparam logic [2:0] REQ_FRAG = 3'd2;
   localparam logic [2:0] REQ_HQ   = 3'd3;
   localparam logic [2:0] REQ_MAPQ = 3'd4;

   // register indexes
   localparam logic [2:0] CSR_HQ_MIN    = 3'd0;
   localparam logic [2:0] CSR_AUTO_MASK = 3'd1;
   localparam logic [2:0] CSR_MITO_ID   = 3'd2;
   localparam logic [2:0] CSR_SHORT_LO  = 3'd3;
   localparam logic [2:0] CSR_SHORT_HI  = 3'd4;
   localparam logic [2:0] CSR_MONO_LO   = 3'd5;
   localparam logic [2:0] CSR_MONO_HI   = 3'd6;

   // flag bit positions
   localparam int F_PAIRED = 0;
   localparam int F_PROPER = 1;
   localparam int F_UNMAP  = 2;
   localparam int F_MUNMAP = 3;
   localparam int F_REV    = 4;
   localparam int F_MREV   = 5;
   localparam int F_FIRST  = 6;
   localparam int F_SECOND = 7;
   localparam int F_SEC    = 8;
   localparam int F_QCFAIL = 9;
   localparam int F_DUP    = 10;
   localparam int F_SUPP   = 11;

   // classes
   localparam logic [3:0] CLS_QCFAIL   = 4'd0;
   localparam logic [3:0] CLS_UNPAIRED = 4'd1;
   localparam logic [3:0] CLS_UNMAP    = 4'd2;
   localparam logic [3:0] CLS_MUNMAP   = 4'd3;
   localparam logic [3:0] CLS_RF       = 4'd4;
   localparam logic [3:0] CLS_FF       = 4'd5;
   localparam logic [3:0] CLS_RR       = 4'd6;
   localparam logic [3:0] CLS_ZEROQ    = 4'd7;
   localparam logic [3:0] CLS_PROP_FR  = 4'd8;
   localparam logic [3:0] CLS_PROP_OTH = 4'd9;
   localparam logic [3:0] CLS_OTHREF   = 4'd10;
   localparam logic [3:0] CLS_IMPROPER = 4'd11;
   localparam logic [3:0] CLS_UNCLASS  = 4'd12;

   // counter indexes
   localparam int C_TOTAL = 0,  C_FWD = 1,  C_REV = 2,  C_SEC = 3,  C_SUPP = 4;
   localparam int C_DUP = 5,    C_FIRST = 6, C_SECOND = 7, C_MFWD = 8, C_MREV = 9;
   localparam int C_PAIRED = 10, C_QCFAIL = 11, C_UNPAIRED = 12, C_UNMAP = 13;
   localparam int C_MUNMAP = 14, C_RF = 15, C_FF = 16, C_RR = 17, C_ZEROQ = 18;
   localparam int C_PMAPPED = 19, C_PROPER = 20, C_FR = 21, C_OTHREF = 22;
   localparam int C_IMPROPER = 23, C_UNCLASS = 24, C_AUTO = 25, C_DUPAUTO = 26;
   localparam int C_HQ = 27, C_HQSHORT = 28, C_HQMONO = 29, C_MITO = 30;
   localparam int C_DUPMITO = 31;

   // classified item handed from front to back
   typedef struct packed {
      logic                    is_add;
      logic [2:0]              kind;
      logic [9:0]              qi;
      logic [3:0]              read_class;
      logic [31:0]             frag;
      logic                    auto_hit;
      logic                    mito_hit;
      logic                    hq;
      logic [NUM_COUNTERS-1:0] bump;
      logic [7:0]              mapq;
      logic                    frag_upd;
      logic                    hq_upd;
   } item_type;

   typedef struct packed {
      logic [39:0] read_value;
      logic        hq_autosomal;
      logic        mito_hit;
      logic        autosomal_hit;
      logic [31:0] fragment_len;
      logic [3:0]  read_class;
   } resp_type;
endpackage
`default_nettype wire

@@ sv/arfc_ram.sv @@
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module arfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      if (re) rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ sv/arfc_fifo.sv @@
// Short item queue between classifier front and update back.
// Depends on arfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "aligned_read_flag_classifier_defines.svh"
module arfc_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire arfc_pkg::item_type din,
   input  wire logic              pop,
   output arfc_pkg::item_type     dout,
   output logic                   full,
   output logic                   empty
);
   localparam int PW = $clog2(arfc_pkg::QDEPTH);

   arfc_pkg::item_type mem_ff [arfc_pkg::QDEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PW+1)'(arfc_pkg::QDEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= din;
   end

   `ARFC_ASSERT_IMP(a_no_overflow, push, !full || pop)
   `ARFC_ASSERT_IMP(a_no_underflow, pop, !empty)
   `ARFC_ASSERT_NEXT(a_count_bound, 1'b1, cnt_ff <= (PW+1)'(arfc_pkg::QDEPTH))
endmodule
`default_nettype wire

@@ sv/arfc_front.sv @@
// Front: configuration registers and read classification.
// Depends on arfc_pkg; feeds arfc_fifo.
`timescale 1ns / 1ps
`default_nettype none
module arfc_front #(
   parameter int NUM_REFS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic [2:0]        csr_index,
   input  wire logic [63:0]       csr_data,
   input  wire logic [2:0]        req_type,
   input  wire logic [11:0]       flags,
   input  wire logic [7:0]        mapq,
   input  wire logic signed [6:0] ref_id,
   input  wire logic signed [6:0] mate_ref_id,
   input  wire logic [30:0]       pos,
   input  wire logic [30:0]       mate_pos,
   input  wire logic signed [31:0] template_len,
   input  wire logic [9:0]        query_index,
   output arfc_pkg::item_type     item
);
   logic [7:0]  hq_min_ff;
   logic [63:0] auto_mask_ff;
   logic [6:0]  mito_id_ff;
   logic [15:0] short_lo_ff, short_hi_ff, mono_lo_ff, mono_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hq_min_ff    <= 8'd30;
         auto_mask_ff <= 64'd4194302;
         mito_id_ff   <= 7'd64;
         short_lo_ff  <= 16'd50;
         short_hi_ff  <= 16'd100;
         mono_lo_ff   <= 16'd150;
         mono_hi_ff   <= 16'd200;
      end else if (csr_valid) begin
         unique case (csr_index)
            arfc_pkg::CSR_HQ_MIN:    hq_min_ff    <= csr_data[7:0];
            arfc_pkg::CSR_AUTO_MASK: auto_mask_ff <= csr_data;
            arfc_pkg::CSR_MITO_ID:   mito_id_ff   <= csr_data[6:0];
            arfc_pkg::CSR_SHORT_LO:  short_lo_ff  <= csr_data[15:0];
            arfc_pkg::CSR_SHORT_HI:  short_hi_ff  <= csr_data[15:0];
            arfc_pkg::CSR_MONO_LO:   mono_lo_ff   <= csr_data[15:0];
            arfc_pkg::CSR_MONO_HI:   mono_hi_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic        neg, pos_ins, rev, mrev, orig, mapped, base, is_fr, is_rf;
   logic        ref_ok, dup, proper;
   logic [31:0] frag;

   always_comb begin
      neg     = template_len[31];
      pos_ins = !neg && (template_len != '0);
      frag    = neg ? (~template_len + 32'd1) : template_len;
      rev     = flags[arfc_pkg::F_REV];
      mrev    = flags[arfc_pkg::F_MREV];
      dup     = flags[arfc_pkg::F_DUP];
      proper  = flags[arfc_pkg::F_PROPER];
      orig    = !flags[arfc_pkg::F_SEC] && !flags[arfc_pkg::F_SUPP];
      mapped  = !flags[arfc_pkg::F_UNMAP] && !flags[arfc_pkg::F_MUNMAP];
      base    = mapped && (ref_id == mate_ref_id) && (pos != '0) && (mate_pos != '0);
      is_fr   = base && ((!rev && mrev && pos_ins) || (rev && !mrev && neg));
      is_rf   = base && (template_len != '0) &&
                ((rev && !mrev && pos_ins) || (!rev && mrev && neg));
      ref_ok  = mapped && !ref_id[6] && (32'(ref_id[5:0]) < NUM_REFS);
   end

   always_comb begin
      item            = '0;
      item.kind       = req_type;
      item.qi         = query_index;
      item.mapq       = mapq;
      if (req_type == arfc_pkg::REQ_ADD) begin
         item.is_add = 1'b1;
         item.frag   = frag;
         item.bump[arfc_pkg::C_TOTAL]  = 1'b1;
         item.bump[arfc_pkg::C_REV]    = rev;
         item.bump[arfc_pkg::C_FWD]    = !rev;
         item.bump[arfc_pkg::C_SEC]    = flags[arfc_pkg::F_SEC];
         item.bump[arfc_pkg::C_SUPP]   = flags[arfc_pkg::F_SUPP];
         item.bump[arfc_pkg::C_DUP]    = dup;
         item.bump[arfc_pkg::C_FIRST]  = flags[arfc_pkg::F_FIRST];
         item.bump[arfc_pkg::C_SECOND] = flags[arfc_pkg::F_SECOND];
         item.bump[arfc_pkg::C_MREV]   = mrev;
         item.bump[arfc_pkg::C_MFWD]   = !mrev;
         item.bump[arfc_pkg::C_PAIRED] = flags[arfc_pkg::F_PAIRED];

         // priority chain, first match wins
         if (flags[arfc_pkg::F_QCFAIL]) begin
            item.read_class = arfc_pkg::CLS_QCFAIL;
            item.bump[arfc_pkg::C_QCFAIL] = 1'b1;
         end else if (!flags[arfc_pkg::F_PAIRED]) begin
            item.read_class = arfc_pkg::CLS_UNPAIRED;
            item.bump[arfc_pkg::C_UNPAIRED] = 1'b1;
         end else if (flags[arfc_pkg::F_UNMAP]) begin
            item.read_class = arfc_pkg::CLS_UNMAP;
            item.bump[arfc_pkg::C_UNMAP] = 1'b1;
         end else if (flags[arfc_pkg::F_MUNMAP]) begin
            item.read_class = arfc_pkg::CLS_MUNMAP;
            item.bump[arfc_pkg::C_MUNMAP] = 1'b1;
         end else if (is_rf) begin
            item.read_class = arfc_pkg::CLS_RF;
            item.bump[arfc_pkg::C_RF] = 1'b1;
         end else if (!rev && !mrev) begin
            item.read_class = arfc_pkg::CLS_FF;
            item.bump[arfc_pkg::C_FF] = 1'b1;
         end else if (rev && mrev) begin
            item.read_class = arfc_pkg::CLS_RR;
            item.bump[arfc_pkg::C_RR] = 1'b1;
         end else if (mapq == '0) begin
            item.read_class = arfc_pkg::CLS_ZEROQ;
            item.bump[arfc_pkg::C_ZEROQ] = 1'b1;
         end else if (mapped) begin
            item.bump[arfc_pkg::C_PMAPPED] = 1'b1;
            if (proper) begin
               item.bump[arfc_pkg::C_PROPER] = 1'b1;
               item.bump[arfc_pkg::C_FR]     = is_fr;
               item.read_class = is_fr ? arfc_pkg::CLS_PROP_FR : arfc_pkg::CLS_PROP_OTH;
               item.frag_upd   = orig;
            end else if (ref_id != mate_ref_id) begin
               item.read_class = arfc_pkg::CLS_OTHREF;
               item.bump[arfc_pkg::C_OTHREF] = 1'b1;
            end else begin
               item.read_class = arfc_pkg::CLS_IMPROPER;
               item.bump[arfc_pkg::C_IMPROPER] = 1'b1;
            end
         end else begin
            item.read_class = arfc_pkg::CLS_UNCLASS;
            item.bump[arfc_pkg::C_UNCLASS] = 1'b1;
         end

         if (ref_ok) begin
            if (auto_mask_ff[ref_id[5:0]]) begin
               item.auto_hit = 1'b1;
               item.bump[arfc_pkg::C_AUTO] = 1'b1;
               if (dup) begin
                  item.bump[arfc_pkg::C_DUPAUTO] = 1'b1;
               end else if (flags[arfc_pkg::F_PAIRED] && proper && orig &&
                            mapq >= hq_min_ff) begin
                  item.hq     = 1'b1;
                  item.hq_upd = 1'b1;
                  item.bump[arfc_pkg::C_HQ] = 1'b1;
                  item.bump[arfc_pkg::C_HQSHORT] =
                     (frag >= 32'(short_lo_ff)) && (frag <= 32'(short_hi_ff));
                  item.bump[arfc_pkg::C_HQMONO] =
                     (frag >= 32'(mono_lo_ff)) && (frag <= 32'(mono_hi_ff));
               end
            end else if (ref_id == mito_id_ff) begin
               item.mito_hit = 1'b1;
               item.bump[arfc_pkg::C_MITO]    = 1'b1;
               item.bump[arfc_pkg::C_DUPMITO] = dup;
            end
         end
      end
   end
endmodule
`default_nettype wire

@@ sv/arfc_back.sv @@
// Back: counters, histogram read-modify-write and result register.
// Depends on arfc_pkg and arfc_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "aligned_read_flag_classifier_defines.svh"
module arfc_back #(
   parameter int FRAG_BINS   = 1024,
   parameter int COUNT_WIDTH = 40
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire arfc_pkg::item_type head,
   input  wire logic               head_valid,
   output logic                    pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output arfc_pkg::resp_type      rsp
);
   localparam int BW = $clog2(FRAG_BINS);
   localparam int MW = $clog2(arfc_pkg::MAPQ_BINS);

   // clearing pass over all histogram memories after reset
   logic [BW:0] clr_ff, clr_in;
   assign clearing = !clr_ff[BW];
   assign clr_in   = clearing ? clr_ff + 1'b1 : clr_ff;

   arfc_pkg::item_type s1_ff;
   logic    s1_valid_ff, s1_valid_in;
   logic    out_free, s1_adv;
   logic [BW-1:0] faddr_ff, faddr_in;
   logic [MW-1:0] qaddr_ff, qaddr_in;

   assign out_free = !rsp_valid || rsp_ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign pop      = head_valid && !clearing && (!s1_valid_ff || out_free);
   assign s1_valid_in = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_comb begin
      if (!head.is_add)
         faddr_in = BW'(head.qi);
      else if (head.frag < 32'(FRAG_BINS))
         faddr_in = BW'(head.frag);
      else
         faddr_in = BW'(FRAG_BINS - 1);
      qaddr_in = head.is_add ? head.mapq : head.qi[MW-1:0];
   end

   logic [31:0] frag_q, hq_q, qual_q;
   logic [31:0] frag_cur, hq_cur, qual_cur, frag_new, hq_new, qual_new;
   logic        frag_we, hq_we, qual_we;

   // one-entry bypass of the last write covers the stale registered read
   logic          ffv_ff, hfv_ff, qfv_ff;
   logic [BW-1:0] ffa_ff, hfa_ff;
   logic [MW-1:0] qfa_ff;
   logic [31:0]   ffd_ff, hfd_ff, qfd_ff;

   always_comb begin
      frag_cur = (ffv_ff && ffa_ff == faddr_ff) ? ffd_ff : frag_q;
      hq_cur   = (hfv_ff && hfa_ff == faddr_ff) ? hfd_ff : hq_q;
      qual_cur = (qfv_ff && qfa_ff == qaddr_ff) ? qfd_ff : qual_q;
      frag_new = (&frag_cur) ? frag_cur : frag_cur + 32'd1;
      hq_new   = (&hq_cur) ? hq_cur : hq_cur + 32'd1;
      qual_new = (&qual_cur) ? qual_cur : qual_cur + 32'd1;
      frag_we  = s1_adv && s1_ff.frag_upd;
      hq_we    = s1_adv && s1_ff.hq_upd;
      qual_we  = s1_adv && s1_ff.is_add;
   end

   arfc_ram #(.WIDTH(32), .DEPTH(FRAG_BINS)) u_frag_ram (
      .clock(clock), .we(frag_we || clearing),
      .waddr(clearing ? clr_ff[BW-1:0] : faddr_ff),
      .wdata(clearing ? 32'd0 : frag_new),
      .re(pop), .raddr(faddr_in), .rdata(frag_q));

   arfc_ram #(.WIDTH(32), .DEPTH(FRAG_BINS)) u_hq_ram (
      .clock(clock), .we(hq_we || clearing),
      .waddr(clearing ? clr_ff[BW-1:0] : faddr_ff),
      .wdata(clearing ? 32'd0 : hq_new),
      .re(pop), .raddr(faddr_in), .rdata(hq_q));

   arfc_ram #(.WIDTH(32), .DEPTH(arfc_pkg::MAPQ_BINS)) u_qual_ram (
      .clock(clock), .we(qual_we || clearing),
      .waddr(clearing ? clr_ff[MW-1:0] : qaddr_ff),
      .wdata(clearing ? 32'd0 : qual_new),
      .re(pop), .raddr(qaddr_in), .rdata(qual_q));

   // category counters and longest proper fragment
   logic [COUNT_WIDTH-1:0] cnt_ff [arfc_pkg::NUM_COUNTERS];
   logic [31:0]            longest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < arfc_pkg::NUM_COUNTERS; i++) cnt_ff[i] <= '0;
         longest_ff <= '0;
      end else if (s1_adv && s1_ff.is_add) begin
         for (int i = 0; i < arfc_pkg::NUM_COUNTERS; i++)
            if (s1_ff.bump[i] && !(&cnt_ff[i])) cnt_ff[i] <= cnt_ff[i] + 1'b1;
         if (s1_ff.frag_upd && longest_ff < s1_ff.frag) longest_ff <= s1_ff.frag;
      end
   end

   logic [39:0]        value;
   arfc_pkg::resp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      value = '0;
      case (s1_ff.kind)
         arfc_pkg::REQ_CNT:
            if (32'(s1_ff.qi) < arfc_pkg::NUM_COUNTERS)
               value = 40'(cnt_ff[s1_ff.qi[4:0]]);
            else if (32'(s1_ff.qi) == arfc_pkg::NUM_COUNTERS)
               value = 40'(longest_ff);
         arfc_pkg::REQ_FRAG:
            if (32'(s1_ff.qi) < FRAG_BINS) value = 40'(frag_cur);
         arfc_pkg::REQ_HQ:
            if (32'(s1_ff.qi) < FRAG_BINS) value = 40'(hq_cur);
         arfc_pkg::REQ_MAPQ:
            if (32'(s1_ff.qi) < arfc_pkg::MAPQ_BINS) value = 40'(qual_cur);
         default: value = '0;
      endcase
      rsp_in.read_class    = s1_ff.read_class;
      rsp_in.fragment_len  = s1_ff.frag;
      rsp_in.autosomal_hit = s1_ff.auto_hit;
      rsp_in.mito_hit      = s1_ff.mito_hit;
      rsp_in.hq_autosomal  = s1_ff.hq;
      rsp_in.read_value    = value;
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ffv_ff       <= 1'b0;
         hfv_ff       <= 1'b0;
         qfv_ff       <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (frag_we) ffv_ff <= 1'b1;
         if (hq_we)   hfv_ff <= 1'b1;
         if (qual_we) qfv_ff <= 1'b1;
      end
      if (pop) begin
         s1_ff    <= head;
         faddr_ff <= faddr_in;
         qaddr_ff <= qaddr_in;
      end
      if (frag_we) begin ffa_ff <= faddr_ff; ffd_ff <= frag_new; end
      if (hq_we)   begin hfa_ff <= faddr_ff; hfd_ff <= hq_new;   end
      if (qual_we) begin qfa_ff <= qaddr_ff; qfd_ff <= qual_new; end
      if (s1_adv) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `ARFC_ASSERT_IMP(a_no_pop_in_clear, clearing, !pop && !s1_valid_ff)
   `ARFC_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !out_free, s1_valid_ff)
   `ARFC_ASSERT_NEXT(a_query_zero, s1_adv && !s1_ff.is_add,
      rsp_ff.read_class == '0 && rsp_ff.fragment_len == '0)
endmodule
`default_nettype wire

@@ sv/aligned_read_flag_classifier.sv @@
// Top level of the aligned read flag classifier.
// Depends on arfc_pkg, arfc_front, arfc_fifo, arfc_back.
//
//  channel  | direction | handshake              | payload
//  req      | in        | req_tvalid/req_tready  | req_tdata, req_tuser (request kind)
//  rsp      | out       | rsp_tvalid/rsp_tready  | rsp_tdata
//  csr      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One item per cycle sustained while rsp is not stalled; the result is registered.
// The histogram read-modify-write takes one registered RAM read plus one write,
// with the last write bypassed, so neighboring items to one bin do not stall.
// After reset a clearing pass over every bin zeroes the histograms;
// req_tready stays low until it ends. rsp stalls back up through a 4-deep queue.
`timescale 1ns / 1ps
`default_nettype none
module aligned_read_flag_classifier #(
   parameter int NUM_REFS    = 64,
   parameter int FRAG_BINS   = 1024,
   parameter int COUNT_WIDTH = 40
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [11:0] flags, [19:12] mapq, [26:20] ref_id, [33:27] mate_ref_id,
   // [64:34] pos, [95:65] mate_pos, [127:96] template_len, [137:128] query_index
   input  wire logic [143:0] req_tdata,
   // [2:0] req_type
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [3:0] read_class, [35:4] fragment_len, [36] autosomal_hit, [37] mito_hit,
   // [38] hq_autosomal, [78:39] read_value
   output logic [79:0]       rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_data
);
   arfc_pkg::item_type item, head;
   arfc_pkg::resp_type rsp;
   logic full, empty, pop, clearing, push;

   assign csr_ready  = 1'b1;
   assign req_tready = !full && !clearing;
   assign push       = req_tvalid && req_tready;

   arfc_front #(.NUM_REFS(NUM_REFS)) u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .req_type(req_tuser),
      .flags(req_tdata[11:0]),
      .mapq(req_tdata[19:12]),
      .ref_id(req_tdata[26:20]),
      .mate_ref_id(req_tdata[33:27]),
      .pos(req_tdata[64:34]),
      .mate_pos(req_tdata[95:65]),
      .template_len(req_tdata[127:96]),
      .query_index(req_tdata[137:128]),
      .item(item));

   arfc_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .din(item), .pop(pop), .dout(head),
      .full(full), .empty(empty));

   arfc_back #(.FRAG_BINS(FRAG_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .head(head), .head_valid(!empty), .pop(pop), .clearing(clearing),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(rsp));

   assign rsp_tdata = {1'b0, rsp};
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for aligned_read_flag_classifier.
// Depends on arfc_pkg and the RTL; drives reads, queries and register writes and
// checks each transfer on the result channel against an in-bench classifier.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import arfc_pkg::*;

   localparam int FRAG_BINS = 1024;
   localparam int LIMIT     = 600000;
   localparam logic [11:0] FL_PAIRED = 12'd1 << F_PAIRED;
   localparam logic [11:0] FL_PROPER = 12'd1 << F_PROPER;
   localparam logic [11:0] FL_UNMAP  = 12'd1 << F_UNMAP;
   localparam logic [11:0] FL_MUNMAP = 12'd1 << F_MUNMAP;
   localparam logic [11:0] FL_REV    = 12'd1 << F_REV;
   localparam logic [11:0] FL_MREV   = 12'd1 << F_MREV;
   localparam logic [11:0] FL_FIRST  = 12'd1 << F_FIRST;
   localparam logic [11:0] FL_SECOND = 12'd1 << F_SECOND;
   localparam logic [11:0] FL_SEC    = 12'd1 << F_SEC;
   localparam logic [11:0] FL_QCFAIL = 12'd1 << F_QCFAIL;
   localparam logic [11:0] FL_DUP    = 12'd1 << F_DUP;
   localparam logic [11:0] FL_SUPP   = 12'd1 << F_SUPP;
   localparam logic [11:0] FL_PP     = FL_PAIRED | FL_PROPER;

   typedef struct {
      logic [3:0]  read_class;
      logic [31:0] fragment_len;
      logic        autosomal_hit;
      logic        mito_hit;
      logic        hq_autosomal;
      logic [39:0] read_value;
   } read_result_t;

   class read_stats_board;
      logic [7:0]  hq_min;
      logic [63:0] auto_mask;
      logic [6:0]  mito_id;
      logic [15:0] short_lo, short_hi, mono_lo, mono_hi;
      logic [39:0] counters[NUM_COUNTERS];
      logic [31:0] frag_hist[FRAG_BINS];
      logic [31:0] hq_hist[FRAG_BINS];
      logic [31:0] mapq_hist[MAPQ_BINS];
      logic [31:0] longest;
      read_result_t pending_results[$];
      int errors;
      int checked;

      function new();
         hq_min = 30; auto_mask = 64'h3FFFFE; mito_id = 64;
         short_lo = 50; short_hi = 100; mono_lo = 150; mono_hi = 200;
         foreach (counters[i]) counters[i] = '0;
         foreach (frag_hist[i]) frag_hist[i] = '0;
         foreach (hq_hist[i]) hq_hist[i] = '0;
         foreach (mapq_hist[i]) mapq_hist[i] = '0;
         longest = '0; errors = 0; checked = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] val);
         case (idx)
            CSR_HQ_MIN:    hq_min = val[7:0];
            CSR_AUTO_MASK: auto_mask = val;
            CSR_MITO_ID:   mito_id = val[6:0];
            CSR_SHORT_LO:  short_lo = val[15:0];
            CSR_SHORT_HI:  short_hi = val[15:0];
            CSR_MONO_LO:   mono_lo = val[15:0];
            CSR_MONO_HI:   mono_hi = val[15:0];
            default: ;
         endcase
      endfunction

      function void bump(int idx);
         if (counters[idx] != '1) counters[idx]++;
      endfunction

      function int frag_bin(logic [31:0] len);
         return (len >= FRAG_BINS) ? FRAG_BINS - 1 : int'(len);
      endfunction

      // classify one accepted request and queue the result it must produce
      function void note_request(logic [2:0] kind, logic [143:0] d);
         logic [11:0] fl;
         logic [7:0]  mq;
         logic [6:0]  tid, mtid;
         logic [30:0] p, mp;
         logic [31:0] raw, frag;
         logic [9:0]  qi;
         bit neg, pins, rev, mrev, orig, both, geo, fr, rf;
         read_result_t e;
         fl = d[11:0]; mq = d[19:12]; tid = d[26:20]; mtid = d[33:27];
         p = d[64:34]; mp = d[95:65]; raw = d[127:96]; qi = d[137:128];
         e = '{default: '0};
         if (kind != REQ_ADD) begin
            case (kind)
               REQ_CNT:
                  if (qi < NUM_COUNTERS) e.read_value = counters[qi];
                  else if (qi == NUM_COUNTERS) e.read_value = {8'd0, longest};
               REQ_FRAG: if (qi < FRAG_BINS) e.read_value = {8'd0, frag_hist[qi]};
               REQ_HQ:   if (qi < FRAG_BINS) e.read_value = {8'd0, hq_hist[qi]};
               REQ_MAPQ: if (qi < MAPQ_BINS) e.read_value = {8'd0, mapq_hist[qi]};
               default: ;
            endcase
            pending_results.insert(pending_results.size(), e);
            return;
         end
         neg = raw[31];
         frag = neg ? (~raw + 32'd1) : raw;
         pins = !neg && raw != 0;
         rev = fl[F_REV]; mrev = fl[F_MREV];
         orig = !fl[F_SEC] && !fl[F_SUPP];
         both = !fl[F_UNMAP] && !fl[F_MUNMAP];
         geo = both && tid == mtid && p != 0 && mp != 0;
         fr = geo && ((!rev && mrev && pins) || (rev && !mrev && neg));
         rf = geo && raw != 0 && ((rev && !mrev && pins) || (!rev && mrev && neg));

         bump(C_TOTAL);
         if (mapq_hist[mq] != '1) mapq_hist[mq]++;
         bump(rev ? C_REV : C_FWD);
         if (fl[F_SEC]) bump(C_SEC);
         if (fl[F_SUPP]) bump(C_SUPP);
         if (fl[F_DUP]) bump(C_DUP);
         if (fl[F_FIRST]) bump(C_FIRST);
         if (fl[F_SECOND]) bump(C_SECOND);
         bump(mrev ? C_MREV : C_MFWD);
         if (fl[F_PAIRED]) bump(C_PAIRED);

         if (fl[F_QCFAIL]) begin e.read_class = CLS_QCFAIL; bump(C_QCFAIL); end
         else if (!fl[F_PAIRED]) begin e.read_class = CLS_UNPAIRED; bump(C_UNPAIRED); end
         else if (fl[F_UNMAP]) begin e.read_class = CLS_UNMAP; bump(C_UNMAP); end
         else if (fl[F_MUNMAP]) begin e.read_class = CLS_MUNMAP; bump(C_MUNMAP); end
         else if (rf) begin e.read_class = CLS_RF; bump(C_RF); end
         else if (!rev && !mrev) begin e.read_class = CLS_FF; bump(C_FF); end
         else if (rev && mrev) begin e.read_class = CLS_RR; bump(C_RR); end
         else if (mq == 0) begin e.read_class = CLS_ZEROQ; bump(C_ZEROQ); end
         else if (both) begin
            bump(C_PMAPPED);
            if (fl[F_PROPER]) begin
               bump(C_PROPER);
               if (fr) bump(C_FR);
               e.read_class = fr ? CLS_PROP_FR : CLS_PROP_OTH;
               if (orig) begin
                  if (frag_hist[frag_bin(frag)] != '1) frag_hist[frag_bin(frag)]++;
                  if (longest < frag) longest = frag;
               end
            end else if (tid != mtid) begin
               e.read_class = CLS_OTHREF; bump(C_OTHREF);
            end else begin
               e.read_class = CLS_IMPROPER; bump(C_IMPROPER);
            end
         end else begin
            e.read_class = CLS_UNCLASS; bump(C_UNCLASS);
         end

         // negative ref ids count as no reference
         if (both && !tid[6]) begin
            if (auto_mask[tid[5:0]]) begin
               e.autosomal_hit = 1; bump(C_AUTO);
               if (fl[F_DUP]) bump(C_DUPAUTO);
               else if (fl[F_PAIRED] && fl[F_PROPER] && orig && mq >= hq_min) begin
                  e.hq_autosomal = 1; bump(C_HQ);
                  if (hq_hist[frag_bin(frag)] != '1) hq_hist[frag_bin(frag)]++;
                  if (short_lo <= frag && frag <= short_hi) bump(C_HQSHORT);
                  if (mono_lo <= frag && frag <= mono_hi) bump(C_HQMONO);
               end
            end else if (tid == mito_id) begin
               e.mito_hit = 1; bump(C_MITO);
               if (fl[F_DUP]) bump(C_DUPMITO);
            end
         end
         e.fragment_len = frag;
         pending_results.insert(pending_results.size(), e);
      endfunction

      function void check_result(logic [79:0] t);
         read_result_t e;
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected: %h", t);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         checked++;
         if (t[3:0] !== e.read_class) begin
            $error("read_class expected %0d got %0d", e.read_class, t[3:0]); errors++;
         end
         if (t[35:4] !== e.fragment_len) begin
            $error("fragment_len expected %0d got %0d", e.fragment_len, t[35:4]); errors++;
         end
         if (t[36] !== e.autosomal_hit) begin
            $error("autosomal_hit expected %0b got %0b", e.autosomal_hit, t[36]); errors++;
         end
         if (t[37] !== e.mito_hit) begin
            $error("mito_hit expected %0b got %0b", e.mito_hit, t[37]); errors++;
         end
         if (t[38] !== e.hq_autosomal) begin
            $error("hq_autosomal expected %0b got %0b", e.hq_autosomal, t[38]); errors++;
         end
         if (t[78:39] !== e.read_value) begin
            $error("read_value expected %0d got %0d", e.read_value, t[78:39]); errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [79:0]  rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [63:0]  csr_data = '0;

   read_stats_board board = new();
   int  cycles = 0;
   bit  calm = 0;
   int  n_reads = 0, n_queries = 0;

   aligned_read_flag_classifier uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("aligned_read_flag_classifier regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_request(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result-side backpressure
   initial begin
      @(negedge reset);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 0;
            repeat (gap_len() + 1) @(posedge clock);
         end
         rsp_tready <= 1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic send(input logic [2:0] kind, input logic [143:0] data);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic add_read(input logic [11:0] fl, input logic [7:0] mq,
                           input logic [6:0] tid, input logic [6:0] mtid,
                           input logic [30:0] p, input logic [30:0] mp,
                           input logic [31:0] tlen);
      send(REQ_ADD, {6'd0, 10'd0, tlen, mp, p, mtid, tid, mq, fl});
      n_reads++;
   endtask

   task automatic query(input logic [2:0] kind, input logic [9:0] qi);
      send(kind, {6'd0, qi, 128'd0});
      n_queries++;
   endtask

   // sender waits until every expected transfer is back, then lets the pipe empty
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [7:0] hq, input logic [63:0] mask,
                            input logic [6:0] mito, input logic [15:0] slo,
                            input logic [15:0] shi, input logic [15:0] mlo,
                            input logic [15:0] mhi);
      write_csr(CSR_HQ_MIN, {56'd0, hq});
      write_csr(CSR_AUTO_MASK, mask);
      write_csr(CSR_MITO_ID, {57'd0, mito});
      write_csr(CSR_SHORT_LO, {48'd0, slo});
      write_csr(CSR_SHORT_HI, {48'd0, shi});
      write_csr(CSR_MONO_LO, {48'd0, mlo});
      write_csr(CSR_MONO_HI, {48'd0, mhi});
   endtask

   task automatic random_item();
      logic [11:0] fl;
      logic [6:0]  tid, mtid;
      logic [31:0] tlen, mag;
      logic [9:0]  qi;
      logic [2:0]  kind;
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(1, 4));
         case ($urandom_range(0, 3))
            0: qi = 10'($urandom);
            1: qi = 10'($urandom_range(0, 40));
            2: qi = 10'($urandom_range(0, 300));
            default: qi = 10'($urandom_range(1000, 1023));
         endcase
         query(kind, qi);
      end else if (r < 85) begin
         // well-formed pair with random content
         fl = FL_PP | ($urandom_range(0, 1) ? FL_FIRST : FL_SECOND);
         if ($urandom_range(0, 6) == 0) fl = fl & ~FL_PROPER;
         if ($urandom_range(0, 9) == 0) fl = fl | FL_DUP;
         if ($urandom_range(0, 19) == 0) fl = fl | ($urandom_range(0, 1) ? FL_SEC : FL_SUPP);
         if ($urandom_range(0, 4) == 0) fl = fl | FL_MREV | ($urandom_range(0, 1) ? FL_REV : 0);
         else fl = fl | ($urandom_range(0, 1) ? FL_REV : FL_MREV);
         tid = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 63))
                                          : 7'($urandom_range(0, 25));
         mtid = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 63)) : tid;
         mag = ($urandom_range(0, 9) == 0) ? $urandom_range(1024, 70000)
                                           : $urandom_range(1, 1100);
         tlen = fl[F_REV] ? -mag : mag;
         if ($urandom_range(0, 15) == 0) tlen = -tlen;
         add_read(fl, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60)),
                  tid, mtid, 31'($urandom_range(1, 32'h7FFFFFFF)),
                  31'($urandom_range(1, 32'h7FFFFFFF)), tlen);
      end else begin
         tlen = $urandom;
         if ($urandom_range(0, 3) == 0) tlen = 32'($signed(10'($urandom)));
         add_read(12'($urandom), 8'($urandom),
                  ($urandom_range(0, 4) == 0) ? 7'h7F : 7'($urandom_range(0, 63)),
                  ($urandom_range(0, 4) == 0) ? 7'h7F : 7'($urandom_range(0, 63)),
                  ($urandom_range(0, 4) == 0) ? 31'd0 : 31'($urandom),
                  ($urandom_range(0, 4) == 0) ? 31'd0 : 31'($urandom), tlen);
      end
   endtask

   task automatic random_phase(input int count);
      repeat (count) random_item();
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty state queries, every class but CLS_PROP_OTH and CLS_UNCLASS, edge fields
      calm = 1;
      query(REQ_CNT, 10'd0);
      query(REQ_CNT, 10'd33);
      query(REQ_MAPQ, 10'd1023);
      query(3'd5, 10'd1);
      query(3'd7, 10'd1023);
      add_read(FL_QCFAIL | FL_PAIRED, 8'd40, 7'd1, 7'd1, 31'd100, 31'd200, 32'd150);
      add_read(12'd0, 8'd40, 7'd1, 7'd1, 31'd100, 31'd200, 32'd150);
      add_read(FL_PP | FL_UNMAP, 8'd40, 7'h7F, 7'd1, 31'd0, 31'd200, 32'd0);
      add_read(FL_PP | FL_MUNMAP, 8'd40, 7'd1, 7'h7F, 31'd100, 31'd0, 32'd0);
      add_read(FL_PP | FL_REV, 8'd40, 7'd2, 7'd2, 31'd300, 31'd100, 32'd200);
      add_read(FL_PP, 8'd40, 7'd2, 7'd2, 31'd100, 31'd300, 32'd200);
      add_read(FL_PP | FL_REV | FL_MREV, 8'd40, 7'd2, 7'd2, 31'd100, 31'd300, 32'd200);
      add_read(FL_PP | FL_MREV, 8'd0, 7'd2, 7'd2, 31'd100, 31'd300, 32'd200);
      add_read(FL_PP | FL_MREV, 8'd255, 7'd3, 7'd3, 31'd100, 31'd180, 32'd80);
      add_read(FL_PP | FL_MREV, 8'd40, 7'd3, 7'd3, 31'd100, 31'd300, -32'd200);
      add_read(FL_PAIRED | FL_MREV, 8'd40, 7'd3, 7'd5, 31'd100, 31'd300, 32'd200);
      add_read(FL_PAIRED | FL_MREV, 8'd40, 7'd3, 7'd3, 31'd100, 31'd300, 32'd200);
      add_read(FL_PP | FL_MREV, 8'd40, 7'd4, 7'd4, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'd5000);
      add_read(FL_PP | FL_REV | FL_DUP, 8'd40, 7'd5, 7'd5, 31'd9, 31'd1, 32'h80000000);
      add_read(FL_PP | FL_MREV, 8'd40, 7'd63, 7'd63, 31'd100, 31'd300, 32'h7FFFFFFF);
      add_read(12'hFFF, 8'd0, 7'h7F, 7'h7F, 31'd0, 31'd0, 32'd0);
      query(REQ_CNT, 10'd32);
      query(REQ_FRAG, 10'd1023);
      query(REQ_HQ, 10'd200);
      query(REQ_MAPQ, 10'd255);
      drain();
      calm = 0;

      random_phase(330);
      write_all(8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      random_phase(330);
      write_all(8'd255, 64'd0, 7'd63, 16'hFFFF, 16'd0, 16'd200, 16'd100);
      random_phase(330);
      write_all(8'd20, 64'h00FF_FFFF, 7'd24, 16'd30, 16'd120, 16'd121, 16'd400);
      calm = 1;
      repeat (120) random_item();
      calm = 0;
      random_phase(210);
      write_all(8'($urandom), {$urandom, $urandom}, 7'($urandom_range(0, 64)),
                16'($urandom_range(0, 300)), 16'($urandom_range(0, 600)),
                16'($urandom_range(0, 300)), 16'($urandom_range(0, 1200)));
      random_phase(330);
      // read back every counter and the longest fragment
      for (int i = 0; i <= NUM_COUNTERS; i++) query(REQ_CNT, 10'(i));
      drain();

      if (board.pending_results.size() != 0) begin
         $error("%0d expected results never arrived", board.pending_results.size());
         board.errors++;
      end
      $display("Covered %0d reads and %0d queries over 5 register settings, %0d results checked.",
               n_reads, n_queries, board.checked);
      if (board.errors == 0)
         $display("aligned_read_flag_classifier regression: pass");
      else
         $display("aligned_read_flag_classifier regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/arfc_pkg.sv
sv/arfc_ram.sv
sv/arfc_fifo.sv
sv/arfc_front.sv
sv/arfc_back.sv
sv/aligned_read_flag_classifier.sv
test/tb_top.sv
